// ----- rtl/core/mots_pkg.sv -----
// Package for the minimum-first topological sort unit.
// Holds the capacity constants and the input and result word types.
// No dependencies.
`default_nettype none

package mots_pkg;

	// Capacity of the graph store.
	localparam int MAX_NODES = 64;
	localparam int MAX_EDGES = 256;

	// Field widths fixed by the interface.
	localparam int NODE_W  = 6;
	localparam int COUNT_W = 7;

	// Edge store addressing and in-degree width (counts up to MAX_EDGES).
	localparam int EDGE_AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
	localparam int EDGE_CW = $clog2(MAX_EDGES + 1);
	localparam int DEG_W   = EDGE_CW;

	// Command codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_RUN  = 1'b1;

	// Input word: one edge load or one run request.
	typedef struct packed {
		logic              cmd;
		logic [NODE_W-1:0] src_node;
		logic [NODE_W-1:0] dst_node;
	} in_word_t;

	// Result word: one node of the order.
	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic              node_valid;
		logic              last;
		logic              incomplete;
		logic              overflow;
	} out_word_t;

endpackage

`default_nettype wire

// ----- rtl/core/min_order_topological_sort_unit.sv -----
// Minimum-first topological sort unit (Kahn's method); depends on mots_pkg for types.
// One word at a time, the input stalls until it is done: a stored edge passes through S_INC
// (in-degree read-modify-write), while an ignored or dropped edge does not stall the input. A run,
// per emitted node, scans the nodes and then walks every stored edge (S_EREAD, S_EDATA, S_DEC
// per matching edge), then closes with a final scan; a stalled result word holds the sequencer.
// Reset is asynchronous and resets all control state; the stores need no clearing pass.
`default_nettype none

module min_order_topological_sort_unit (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	output logic                        in_stall,
	input  mots_pkg::in_word_t          in_data,
	output logic                        out_valid,
	input  wire                         out_stall,
	output mots_pkg::out_word_t         out_data,
	input  wire                         cfg_we,
	input  wire [mots_pkg::COUNT_W-1:0] cfg_wdata
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INC,
		S_SCAN,
		S_EREAD,
		S_EDATA,
		S_DEC
	} state_t;

	typedef struct packed {
		logic [mots_pkg::NODE_W-1:0] src;
		logic [mots_pkg::NODE_W-1:0] dst;
	} edge_t;

	state_t                              state_q;
	logic [mots_pkg::COUNT_W-1:0]        node_count_q;
	logic [mots_pkg::EDGE_CW-1:0]        edge_total_q;
	logic [mots_pkg::EDGE_CW-1:0]        edge_idx_q;
	logic [mots_pkg::MAX_NODES-1:0]      zero_q;
	logic [mots_pkg::MAX_NODES-1:0]      emitted_q;
	logic                                ovf_q;
	logic [mots_pkg::COUNT_W-1:0]        scan_q;
	logic [mots_pkg::COUNT_W-1:0]        picks_q;
	logic                                pend_vld_q;
	logic [mots_pkg::NODE_W-1:0]         pend_q;
	logic [mots_pkg::NODE_W-1:0]         pick_q;
	logic [mots_pkg::NODE_W-1:0]         tgt_q;
	logic                                out_vld_q;
	mots_pkg::out_word_t                 out_q;

	edge_t                               edge_mem [mots_pkg::MAX_EDGES];
	edge_t                               edge_rd_q;
	logic [mots_pkg::DEG_W-1:0]          deg_mem [mots_pkg::MAX_NODES];
	logic [mots_pkg::DEG_W-1:0]          deg_rd_q;

	logic [mots_pkg::COUNT_W-1:0]        n_act;
	logic                                in_fire;
	logic                                out_free;
	logic                                load_ok;
	logic                                scan_done;
	logic                                scan_hit;
	logic                                edge_hit;
	logic                                fin_fire;
	logic                                out_load;
	logic                                edge_we;
	logic                                deg_we;
	logic [mots_pkg::NODE_W-1:0]         deg_waddr;
	logic [mots_pkg::DEG_W-1:0]          deg_wdata;
	logic [mots_pkg::NODE_W-1:0]         deg_raddr;
	logic [mots_pkg::DEG_W-1:0]          deg_dec;

	// Active node count, saturated at the node capacity.
	assign n_act = (node_count_q > mots_pkg::COUNT_W'(mots_pkg::MAX_NODES))
		? mots_pkg::COUNT_W'(mots_pkg::MAX_NODES) : node_count_q;

	// Handshake decodes.
	assign in_stall  = (state_q != S_IDLE);
	assign in_fire   = in_valid && !in_stall;
	assign out_free  = !out_vld_q || !out_stall;
	assign out_valid = out_vld_q;
	assign out_data  = out_q;

	// An edge is stored when both ends are in range and the store has room.
	assign load_ok = ({1'b0, in_data.src_node} < n_act) && ({1'b0, in_data.dst_node} < n_act);
	assign edge_we = in_fire && (in_data.cmd == mots_pkg::CMD_LOAD) && load_ok
		&& (edge_total_q < mots_pkg::EDGE_CW'(mots_pkg::MAX_EDGES));

	// Scan step: end of the node range, or a ready node not yet emitted.
	assign scan_done = (scan_q >= n_act);
	assign scan_hit  = !scan_done && !emitted_q[scan_q[mots_pkg::NODE_W-1:0]]
		&& zero_q[scan_q[mots_pkg::NODE_W-1:0]];
	assign fin_fire  = (state_q == S_SCAN) && scan_done && out_free;

	// The result register takes a new word on the closing word or on a released pick.
	assign out_load  = fin_fire || ((state_q == S_SCAN) && scan_hit && pend_vld_q && out_free);

	// Edge walk: a stored edge from the picked node to a live target with count above zero.
	assign edge_hit = (edge_rd_q.src == pick_q) && ({1'b0, edge_rd_q.dst} < n_act)
		&& !zero_q[edge_rd_q.dst];

	// In-degree store port selection.
	assign deg_dec   = deg_rd_q - mots_pkg::DEG_W'(1);
	assign deg_raddr = (state_q == S_EDATA) ? edge_rd_q.dst : in_data.dst_node;
	always_comb begin
		deg_we    = 1'b0;
		deg_waddr = tgt_q;
		deg_wdata = deg_dec;
		if (state_q == S_INC) begin
			deg_we    = 1'b1;
			deg_wdata = (zero_q[tgt_q] ? '0 : deg_rd_q) + mots_pkg::DEG_W'(1);
		end else if (state_q == S_DEC) begin
			deg_we = 1'b1;
		end
	end

	// Edge store: one write port for loads, one registered read port for the walk.
	always_ff @(posedge clk) begin
		if (edge_we) begin
			edge_mem[edge_total_q[mots_pkg::EDGE_AW-1:0]] <= '{src: in_data.src_node,
				dst: in_data.dst_node};
		end
		edge_rd_q <= edge_mem[edge_idx_q[mots_pkg::EDGE_AW-1:0]];
	end

	// In-degree store: the zero flags stand in for valid bits.
	always_ff @(posedge clk) begin
		if (deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
		deg_rd_q <= deg_mem[deg_raddr];
	end

	// Sequencer with its registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			node_count_q <= mots_pkg::COUNT_W'(1);
			edge_total_q <= '0;
			edge_idx_q   <= '0;
			zero_q       <= '1;
			emitted_q    <= '0;
			ovf_q        <= 1'b0;
			scan_q       <= '0;
			picks_q      <= '0;
			pend_vld_q   <= 1'b0;
			pend_q       <= '0;
			pick_q       <= '0;
			tgt_q        <= '0;
			out_vld_q    <= 1'b0;
			out_q        <= '0;
		end else begin
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (out_vld_q && !out_stall) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						if (in_data.cmd == mots_pkg::CMD_RUN) begin
							scan_q  <= '0;
							state_q <= S_SCAN;
						end else if (edge_we) begin
							edge_total_q <= edge_total_q + mots_pkg::EDGE_CW'(1);
							tgt_q        <= in_data.dst_node;
							state_q      <= S_INC;
						end else if (load_ok) begin
							ovf_q <= 1'b1;
						end
					end
				end
				S_INC: begin
					zero_q[tgt_q] <= 1'b0;
					state_q       <= S_IDLE;
				end
				S_SCAN: begin
					if (scan_done) begin
						// Close the run with its last word and clear the graph.
						if (out_free) begin
							if (pend_vld_q) begin
								out_q <= '{node: pend_q, node_valid: 1'b1, last: 1'b1,
									incomplete: (picks_q < n_act), overflow: ovf_q};
							end else begin
								out_q <= '{node: '0, node_valid: 1'b0, last: 1'b1,
									incomplete: (n_act != '0), overflow: ovf_q};
							end
							edge_total_q <= '0;
							zero_q       <= '1;
							emitted_q    <= '0;
							ovf_q        <= 1'b0;
							picks_q      <= '0;
							pend_vld_q   <= 1'b0;
							state_q      <= S_IDLE;
						end
					end else if (scan_hit) begin
						// A new pick releases the previous one as a non-final word.
						if (!pend_vld_q || out_free) begin
							if (pend_vld_q) begin
								out_q <= '{node: pend_q, node_valid: 1'b1, last: 1'b0,
									incomplete: 1'b0, overflow: 1'b0};
							end
							emitted_q[scan_q[mots_pkg::NODE_W-1:0]] <= 1'b1;
							pend_vld_q <= 1'b1;
							pend_q     <= scan_q[mots_pkg::NODE_W-1:0];
							pick_q     <= scan_q[mots_pkg::NODE_W-1:0];
							picks_q    <= picks_q + mots_pkg::COUNT_W'(1);
							edge_idx_q <= '0;
							state_q    <= S_EREAD;
						end
					end else begin
						scan_q <= scan_q + mots_pkg::COUNT_W'(1);
					end
				end
				S_EREAD: begin
					// The read of the current edge is issued from edge_idx_q.
					if (edge_idx_q == edge_total_q) begin
						scan_q  <= '0;
						state_q <= S_SCAN;
					end else begin
						state_q <= S_EDATA;
					end
				end
				S_EDATA: begin
					if (edge_hit) begin
						tgt_q   <= edge_rd_q.dst;
						state_q <= S_DEC;
					end else begin
						edge_idx_q <= edge_idx_q + mots_pkg::EDGE_CW'(1);
						state_q    <= S_EREAD;
					end
				end
				S_DEC: begin
					if (deg_dec == '0) begin
						zero_q[tgt_q] <= 1'b1;
					end
					edge_idx_q <= edge_idx_q + mots_pkg::EDGE_CW'(1);
					state_q    <= S_EREAD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The edge count never passes the store capacity.
	a_total_cap: assert property (@(posedge clk) disable iff (!arst_n)
		edge_total_q <= mots_pkg::EDGE_CW'(mots_pkg::MAX_EDGES))
		else $error("edge count beyond capacity");

	// Closing a run leaves an empty graph behind.
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		fin_fire |=> (edge_total_q == '0) && (emitted_q == '0) && !ovf_q && !pend_vld_q)
		else $error("graph not cleared after run");

	// A held pick has always been marked as emitted.
	a_pend_marked: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> emitted_q[pend_q])
		else $error("pending node not marked emitted");

	// A word without a node is the only word of its run and carries node zero.
	a_empty_word: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !out_q.node_valid) |-> (out_q.last && (out_q.node == '0)))
		else $error("malformed empty result");

endmodule

`default_nettype wire
